// ----- design/mbpc_pkg.sv -----
// mbpc_pkg: shared types and constants for the multi-button press classifier
// used by mbpc_btn_cell and multi_button_press_classifier_core; no dependencies

package mbpc_pkg;

    // width of every configuration register
    localparam int CFG_WIDTH = 16;

    // configuration register indexes
    localparam logic [1:0] REG_SHORT_PRESS = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS  = 2'd1;
    localparam logic [1:0] REG_COMBO       = 2'd2;

    // configuration reset values
    localparam logic [CFG_WIDTH-1:0] SHORT_PRESS_RESET = 16'd5;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET  = 16'd100;
    localparam logic [CFG_WIDTH-1:0] COMBO_RESET       = 16'd20;

    // per-button press class
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_LONG  = 2'd2
    } press_class_t;

    // thresholds broadcast to every button cell
    typedef struct packed {
        logic [CFG_WIDTH-1:0] short_ticks;
        logic [CFG_WIDTH-1:0] long_ticks;
        logic [CFG_WIDTH-1:0] combo_ticks;
    } cfg_t;

    // status rippled from one button cell to the next
    typedef struct packed {
        logic       stop;          // a released short press was taken earlier in the row
        logic       long_seen;     // a long class was seen before the stop point
        logic       report;        // a valid press is being reported
        logic       short_present; // the reported press includes a short button
        logic [1:0] short_button;  // index of that short button
        logic [2:0] long_count;    // running count of long buttons in the report
    } chain_t;

endpackage

// ----- design/multi_button_press_classifier_core.sv -----
// multi_button_press_classifier_core: top level with config registers,
// the row of mbpc_btn_cell instances and the output register; uses mbpc_pkg
// output: a result is registered and appears on the master side in the cycle after its request is accepted
// throughput: one request per cycle unless m_tready stalls; every button cell updates in the cycle its request
//   is accepted, the ripple through the row (BUTTON_COUNT cells) only sets the clock period
// reset: rst_n clears all hold counts, classes, valid flags and the active flag,
//   empties the output register and loads the default thresholds 5, 100 and 20
// s_tready stays high while the output register is empty or being drained

module multi_button_press_classifier_core
    import mbpc_pkg::*;
#(
    parameter int BUTTON_COUNT = 4,
    parameter int HOLD_WIDTH   = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [3:0] pressed_levels, [7:4] zero
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [0] short_present, [2:1] short_button,
                                            // [6:3] long_mask, [9:7] long_count,
                                            // [10] awaiting_release, [15:11] zero
    output logic                 m_tuser    // [0] report_valid
);

    cfg_t cfg_reg;
    logic active_reg;
    logic active_next;

    logic        out_valid_reg;
    logic        out_report_reg;
    logic        out_short_reg;
    logic [1:0]  out_button_reg;
    logic [3:0]  out_mask_reg;
    logic [2:0]  out_count_reg;
    logic        out_await_reg;

    logic                    accept;
    logic [3:0]              levels;
    logic [BUTTON_COUNT-1:0] pushed;
    logic [BUTTON_COUNT-1:0] mask_vec;
    logic [BUTTON_COUNT-1:0] valid_vec;
    logic [3:0]              long_mask;
    chain_t                  chain [BUTTON_COUNT+1];
    chain_t                  tail;
    logic                    join_all;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign levels   = s_tdata[3:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks <= SHORT_PRESS_RESET;
            cfg_reg.long_ticks  <= LONG_PRESS_RESET;
            cfg_reg.combo_ticks <= COMBO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHORT_PRESS: cfg_reg.short_ticks <= cfg_data;
                REG_LONG_PRESS:  cfg_reg.long_ticks  <= cfg_data;
                REG_COMBO:       cfg_reg.combo_ticks <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // row of button cells
    assign chain[0] = '0;
    assign tail     = chain[BUTTON_COUNT];
    assign join_all = !active_reg && tail.long_seen;

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_btn
        if (i < 4)
        begin : g_wired
            assign pushed[i] = levels[i];
        end
        else
        begin : g_absent
            assign pushed[i] = 1'b0;
        end

        mbpc_btn_cell #(
            .IDX        (i),
            .HOLD_WIDTH (HOLD_WIDTH)
        ) u_btn_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (accept),
            .pushed    (pushed[i]),
            .active    (active_reg),
            .join_all  (join_all),
            .cfg       (cfg_reg),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .mask_bit  (mask_vec[i]),
            .valid     (valid_vec[i])
        );
    end

    // long mask limited to the field width
    for (genvar j = 0; j < 4; j++)
    begin : g_mask
        if (j < BUTTON_COUNT)
        begin : g_bit
            assign long_mask[j] = mask_vec[j];
        end
        else
        begin : g_zero
            assign long_mask[j] = 1'b0;
        end
    end

    // active flag: armed from idle by a released short press or a long class, released once no button is pressed
    always_comb
    begin
        if (!active_reg)
        begin
            active_next = tail.stop | tail.long_seen;
        end
        else
        begin
            active_next = |pushed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_report_reg <= tail.report;
            out_short_reg  <= tail.short_present;
            out_button_reg <= tail.short_button;
            out_mask_reg   <= long_mask;
            out_count_reg  <= tail.long_count;
            out_await_reg  <= active_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_report_reg;
    assign m_tdata  = {5'd0, out_await_reg, out_count_reg, out_mask_reg,
                       out_button_reg, out_short_reg};

    // a short press is only ever part of a report
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_short_reg) |-> out_report_reg)
        else $error("short press result without report");

    // a request taken while idle never produces a report
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !active_reg) |=> !out_report_reg)
        else $error("report issued from idle tick");

    // any valid button means the block is armed
    assert property (@(posedge clk) disable iff (!rst_n)
        (|valid_vec) |-> active_reg)
        else $error("valid button while not armed");

    // long count matches the long mask when all buttons fit the mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (BUTTON_COUNT <= 4)) |->
            (32'(out_count_reg) == 32'($countones(out_mask_reg))))
        else $error("long count disagrees with long mask");

endmodule

// ----- design/mbpc_btn_cell.sv -----
// mbpc_btn_cell: hold counter, class and valid flag of one button
// depends on mbpc_pkg; instantiated as a row by multi_button_press_classifier_core

module mbpc_btn_cell
    import mbpc_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int HOLD_WIDTH = 16
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   step,
    input  logic   pushed,
    input  logic   active,
    input  logic   join_all,
    input  cfg_t   cfg,
    input  chain_t chain_in,
    output chain_t chain_out,
    output logic   mask_bit,
    output logic   valid
);

    localparam int CW = (HOLD_WIDTH > CFG_WIDTH) ? HOLD_WIDTH : CFG_WIDTH;
    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};
    localparam logic [CW-1:0] HOLD_MAX_EXT = CW'(HOLD_MAX);
    localparam logic [1:0] IDX_CODE = 2'(IDX % 4);

    logic [HOLD_WIDTH-1:0] hold_reg;
    logic [HOLD_WIDTH-1:0] hold_next;
    press_class_t          class_reg;
    press_class_t          class_next;
    logic                  valid_reg;
    logic                  valid_next;

    logic [HOLD_WIDTH-1:0] hold_inc;
    logic [CW-1:0]         hold_ext;
    logic [CW-1:0]         short_ext;
    logic [CW-1:0]         long_ext;
    logic [CW:0]           reach;
    logic [HOLD_WIDTH-1:0] long_clamp;
    press_class_t          class_calc;
    logic                  release_short;
    logic                  join_ok;
    logic                  rep_hit;

    // saturating hold count for this tick
    assign hold_inc  = (pushed && (hold_reg != HOLD_MAX)) ? hold_reg + 1'b1 : hold_reg;
    assign hold_ext  = CW'(hold_inc);
    assign short_ext = CW'(cfg.short_ticks);
    assign long_ext  = CW'(cfg.long_ticks);

    // classing from the updated hold count
    always_comb
    begin
        if ((hold_ext > short_ext) && (hold_ext <= long_ext))
        begin
            class_calc = CLS_SHORT;
        end
        else if (hold_ext >= long_ext)
        begin
            class_calc = CLS_LONG;
        end
        else
        begin
            class_calc = CLS_NONE;
        end
    end

    // join test: long minus hold at most the allowance
    assign reach      = {1'b0, hold_ext} + {1'b0, CW'(cfg.combo_ticks)};
    assign join_ok    = pushed && (reach >= {1'b0, long_ext});
    assign long_clamp = (long_ext > HOLD_MAX_EXT) ? HOLD_MAX : HOLD_WIDTH'(long_ext);

    assign release_short = (class_calc == CLS_SHORT) && !pushed && !chain_in.stop;
    assign rep_hit       = active && valid_reg;

    // ripple to the next cell
    always_comb
    begin
        chain_out           = chain_in;
        mask_bit            = 1'b0;
        chain_out.stop      = chain_in.stop | release_short;
        chain_out.long_seen = chain_in.long_seen |
                              (!chain_in.stop && (class_calc == CLS_LONG));
        if (rep_hit)
        begin
            chain_out.report = 1'b1;
            case (class_reg)
                CLS_SHORT:
                begin
                    chain_out.short_present = 1'b1;
                    chain_out.short_button  = IDX_CODE;
                end
                CLS_LONG:
                begin
                    chain_out.long_count = chain_in.long_count + 3'd1;
                    mask_bit             = 1'b1;
                end
                default:
                begin
                    chain_out.long_count = chain_in.long_count;
                end
            endcase
        end
    end

    // next per-button state
    always_comb
    begin
        if (active)
        begin
            hold_next  = '0;
            class_next = CLS_NONE;
            valid_next = 1'b0;
        end
        else if (join_all && join_ok)
        begin
            hold_next  = long_clamp;
            class_next = CLS_LONG;
            valid_next = 1'b1;
        end
        else
        begin
            hold_next  = hold_inc;
            class_next = class_calc;
            valid_next = release_short;
        end
    end

    // state registers, advanced once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            class_reg <= CLS_NONE;
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            hold_reg  <= hold_next;
            class_reg <= class_next;
            valid_reg <= valid_next;
        end
    end

    assign valid = valid_reg;

endmodule
